>>> rtl/ihtl_pkg.sv
// shared types and constants of the integral hold trim learner
// depends on nothing; used by every module of the block but the divider
`default_nettype none

package ihtl_pkg;

  localparam int TRIM_KNOTS_DEF = 11;

  // configuration register indexes
  localparam logic [2:0] REG_STROKE_MIN   = 3'd0;
  localparam logic [2:0] REG_STROKE_MAX   = 3'd1;
  localparam logic [2:0] REG_TRIM_ENABLED = 3'd2;
  localparam logic [2:0] REG_ENTER_BAND   = 3'd3;
  localparam logic [2:0] REG_EXIT_BAND    = 3'd4;
  localparam logic [2:0] REG_CONFIRM_MS   = 3'd5;
  localparam logic [2:0] REG_RELEASE_MS   = 3'd6;
  localparam logic [2:0] REG_TRIM_LIMIT   = 3'd7;

  // table read selects
  localparam logic [1:0] SEL_QLO = 2'd0;
  localparam logic [1:0] SEL_QHI = 2'd1;
  localparam logic [1:0] SEL_DLO = 2'd2;
  localparam logic [1:0] SEL_DHI = 2'd3;

  typedef struct packed {
    logic              target_settled;
    logic signed [15:0] control_error;
    logic [31:0]        now_ms;
    logic signed [23:0] loop_integral;
    logic [15:0]        demand_position;
    logic [15:0]        query_position;
  } in_t;

  typedef struct packed {
    logic               hold_active;
    logic               hold_entered;
    logic               trim_transferred;
    logic signed [23:0] trim_value;
    logic [15:0]        transfer_total;
  } out_t;

  typedef struct packed {
    logic [15:0] stroke_min;
    logic [15:0] stroke_max;
    logic        trim_enabled;
    logic [11:0] enter_band;
    logic [11:0] exit_band;
    logic [15:0] confirm_ms;
    logic [15:0] release_ms;
    logic [22:0] trim_limit;
  } cfg_t;

  typedef struct packed {
    logic       latch;
    logic       div_start;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       mul_en;
    logic       step_en;
    logic       wr_lo;
    logic       wr_hi;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/ihtl_div.sv
// restoring divider, one quotient bit per cycle, 16 bit divisor
// depends on nothing outside this file
`default_nettype none

module ihtl_div #(
  parameter int NW = 30
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [15:0]   den,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [15:0]   rem_r, den_r;
  logic [NW-1:0] quo_r;
  logic [16:0]   sh;
  logic          qbit;

  // trial subtraction
  always_comb begin
    sh   = {rem_r, quo_r[NW-1]};
    qbit = (sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // shift dividend out, quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= qbit ? 16'(sh - {1'b0, den_r}) : sh[15:0];
      quo_r <= {quo_r[NW-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> rtl/ihtl_datapath.sv
// datapath: input latch, stroke dividers, trim table, hold machine, output register
// depends on ihtl_pkg and ihtl_div
`default_nettype none

module ihtl_datapath #(
  parameter int TRIM_KNOTS = ihtl_pkg::TRIM_KNOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ihtl_pkg::cfg_t cfg,
  input  wire ihtl_pkg::in_t  in_data,
  input  wire ihtl_pkg::cmd_t cmd,
  output ihtl_pkg::sts_t      sts,
  output ihtl_pkg::out_t      out_data
);
  import ihtl_pkg::*;

  localparam int IW  = $clog2(TRIM_KNOTS);
  localparam int KM1 = TRIM_KNOTS - 1;
  localparam int QW  = IW + 8;
  localparam int NW  = 16 + IW + 8;

  typedef struct packed {
    logic [IW-1:0] lo;
    logic [IW-1:0] hi;
    logic [7:0]    w;
  } loc_t;

  // knot placement from a quotient
  function automatic loc_t locate(input logic [15:0] pos, input logic [QW-1:0] q,
                                  input logic [15:0] mn, input logic [15:0] mx);
    loc_t r;
    r.lo = '0;
    r.w  = '0;
    if (mx > mn && pos > mn) begin
      if (pos >= mx) begin
        r.lo = IW'(KM1);
      end else if (q[QW-1:8] >= IW'(KM1)) begin
        r.lo = IW'(KM1);
      end else begin
        r.lo = q[QW-1:8];
        r.w  = q[7:0];
      end
    end
    r.hi = (r.lo == IW'(KM1)) ? r.lo : IW'(r.lo + 1'b1);
    return r;
  endfunction

  in_t           in_r;
  logic [NW-1:0] qnum, dnum, qquo, dquo;
  logic          qdone, ddone;
  loc_t          qloc, dloc;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.latch) in_r <= in_data;
  end

  // dividend for each position
  assign qnum = NW'(NW'(16'(in_r.query_position - cfg.stroke_min)) * NW'(KM1)) << 8;
  assign dnum = NW'(NW'(16'(in_r.demand_position - cfg.stroke_min)) * NW'(KM1)) << 8;

  ihtl_div #(.NW(NW)) u_qdiv (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(qnum),
    .den(16'(cfg.stroke_max - cfg.stroke_min)), .done(qdone), .quo(qquo)
  );

  ihtl_div #(.NW(NW)) u_ddiv (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(dnum),
    .den(16'(cfg.stroke_max - cfg.stroke_min)), .done(ddone), .quo(dquo)
  );

  assign sts.div_done = qdone & ddone;

  assign qloc = locate(in_r.query_position, qquo[QW-1:0], cfg.stroke_min, cfg.stroke_max);
  assign dloc = locate(in_r.demand_position, dquo[QW-1:0], cfg.stroke_min, cfg.stroke_max);

  // trim table memory with per-entry valid bits
  logic signed [23:0]   mem [TRIM_KNOTS];
  logic [TRIM_KNOTS-1:0] vld_r;
  logic [IW-1:0]        rd_addr, wr_addr;
  logic signed [23:0]   rd_data_r, wr_data;
  logic                 rd_vld_r, wr_en;
  logic signed [24:0]   cl_r, cu_r;
  logic                 moved_r;

  always_comb begin
    unique case (cmd.rd_sel)
      SEL_QLO: rd_addr = qloc.lo;
      SEL_QHI: rd_addr = qloc.hi;
      SEL_DLO: rd_addr = dloc.lo;
      default: rd_addr = dloc.hi;
    endcase
  end

  assign wr_en   = (cmd.wr_lo | cmd.wr_hi) & moved_r;
  assign wr_addr = cmd.wr_lo ? dloc.lo : dloc.hi;
  assign wr_data = cmd.wr_lo ? cl_r[23:0] : cu_r[23:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (wr_en) vld_r[wr_addr] <= 1'b1;
  end

  // capture of the four knot values
  logic signed [23:0] t_ql_r, t_qh_r, t_dl_r, t_dh_r, rd_val;
  assign rd_val = rd_vld_r ? rd_data_r : 24'sd0;

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      unique case (cmd.cap_sel)
        SEL_QLO: t_ql_r <= rd_val;
        SEL_QHI: t_qh_r <= rd_val;
        SEL_DLO: t_dl_r <= rd_val;
        default: t_dh_r <= rd_val;
      endcase
    end
  end

  // interpolation products
  logic signed [33:0] p_lo_r, p_hi_r;
  logic signed [34:0] isum;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_lo_r <= 34'(t_ql_r) * 34'($signed({1'b0, 9'(9'd256 - {1'b0, qloc.w})}));
      p_hi_r <= 34'(t_qh_r) * 34'($signed({2'b00, qloc.w}));
    end
  end

  assign isum = 35'(p_lo_r) + 35'(p_hi_r) + 35'sd128;

  // hold machine next state
  logic signed [16:0] e17;
  logic [16:0]        aerr;
  logic               hold_r, epend_r, rpend_r;
  logic [31:0]        estart_r, rstart_r;
  logic               hold_nxt, epend_nxt, rpend_nxt, entered;
  logic [31:0]        estart_nxt, rstart_nxt;

  assign e17  = 17'(in_r.control_error);
  assign aerr = e17[16] ? 17'(-e17) : 17'(e17);

  always_comb begin
    hold_nxt   = hold_r;
    epend_nxt  = epend_r;
    rpend_nxt  = rpend_r;
    estart_nxt = estart_r;
    rstart_nxt = rstart_r;
    entered    = 1'b0;
    if (!in_r.target_settled) begin
      hold_nxt  = 1'b0;
      epend_nxt = 1'b0;
      rpend_nxt = 1'b0;
    end else if (!hold_r) begin
      if (aerr > 17'(cfg.enter_band)) begin
        epend_nxt = 1'b0;
      end else begin
        if (!epend_r) estart_nxt = in_r.now_ms;
        epend_nxt = 1'b1;
        if (32'(in_r.now_ms - estart_nxt) >= 32'(cfg.confirm_ms)) begin
          hold_nxt  = 1'b1;
          entered   = 1'b1;
          epend_nxt = 1'b0;
          rpend_nxt = 1'b0;
        end
      end
    end else if (aerr <= 17'(cfg.exit_band)) begin
      rpend_nxt = 1'b0;
    end else if (!rpend_r) begin
      rpend_nxt  = 1'b1;
      rstart_nxt = in_r.now_ms;
    end else if (32'(in_r.now_ms - rstart_r) >= 32'(cfg.release_ms)) begin
      hold_nxt  = 1'b0;
      epend_nxt = 1'b0;
      rpend_nxt = 1'b0;
    end
  end

  // transfer check
  logic signed [24:0] cl, cu, lim;
  logic               refuse, moved;
  assign cl  = 25'(t_dl_r) + 25'(in_r.loop_integral);
  assign cu  = 25'(t_dh_r) + 25'(in_r.loop_integral);
  assign lim = $signed({2'b00, cfg.trim_limit});
  assign refuse = (cl > lim) || (cl < -lim) || (cu > lim) || (cu < -lim) ||
                  ((in_r.loop_integral < 24'sd128) && (in_r.loop_integral > -24'sd128));
  assign moved = entered & cfg.trim_enabled & ~refuse;

  logic [15:0]        cnt_r;
  logic               entered_r;
  logic signed [23:0] trim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= 1'b0;
      epend_r  <= 1'b0;
      rpend_r  <= 1'b0;
      estart_r <= '0;
      rstart_r <= '0;
      cnt_r    <= '0;
      moved_r  <= 1'b0;
    end else if (cmd.step_en) begin
      hold_r   <= hold_nxt;
      epend_r  <= epend_nxt;
      rpend_r  <= rpend_nxt;
      estart_r <= estart_nxt;
      rstart_r <= rstart_nxt;
      moved_r  <= moved;
      if (moved) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      entered_r <= entered;
      cl_r      <= cl;
      cu_r      <= cu;
      trim_r    <= cfg.trim_enabled ? isum[31:8] : 24'sd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.hold_active      <= hold_r;
      out_data.hold_entered     <= entered_r;
      out_data.trim_transferred <= moved_r;
      out_data.trim_value       <= trim_r;
      out_data.transfer_total   <= cnt_r;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ihtl_ctrl.sv
// controller state machine sequencing one step through the datapath
// depends on ihtl_pkg
`default_nettype none

module ihtl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire ihtl_pkg::sts_t sts,
  output ihtl_pkg::cmd_t      cmd
);
  import ihtl_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_RQL  = 4'd2;
  localparam logic [3:0] S_RQH  = 4'd3;
  localparam logic [3:0] S_RDL  = 4'd4;
  localparam logic [3:0] S_RDH  = 4'd5;
  localparam logic [3:0] S_CAP  = 4'd6;
  localparam logic [3:0] S_STEP = 4'd7;
  localparam logic [3:0] S_WRL  = 4'd8;
  localparam logic [3:0] S_WRH  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, started_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  // commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = ~started_r;
        if (started_r && sts.div_done) state_nxt = S_RQL;
      end
      S_RQL: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_QLO;
        state_nxt  = S_RQH;
      end
      S_RQH: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_QHI;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_QLO;
        state_nxt   = S_RDL;
      end
      S_RDL: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_DLO;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_QHI;
        state_nxt   = S_RDH;
      end
      S_RDH: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_DHI;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_DLO;
        state_nxt   = S_CAP;
      end
      S_CAP: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_DHI;
        cmd.mul_en  = 1'b1;
        state_nxt   = S_STEP;
      end
      S_STEP: begin
        cmd.step_en = 1'b1;
        state_nxt   = S_WRL;
      end
      S_WRL: begin
        cmd.wr_lo = 1'b1;
        state_nxt = S_WRH;
      end
      S_WRH: begin
        cmd.wr_hi = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ovalid_r  <= 1'b0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= (state_r == S_DIV);
      // result beat handshake
      if (cmd.out_load) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/integral_hold_trim_learner.sv
// Integral hold and trim learner. Each input beat is one control step and
// gives one result beat. A step accepts the beat, starts two one-bit-per-cycle
// dividers that run side by side for the query and demand stroke coordinates,
// waits until their done flag is seen, then sequences the four trim-table
// reads, interpolation, hold update, two knot writes and the output load. A
// new input beat is taken only once the previous step is through. A finished
// result waits in an output register, so the next step is taken while it is
// still unread. Configuration is written through a plain write port; it is to
// be written only while no step is in flight, which the user must keep to, as
// the block itself does not enforce it.
// depends on ihtl_pkg, ihtl_ctrl, ihtl_datapath
`default_nettype none

module integral_hold_trim_learner #(
  parameter int TRIM_KNOTS = ihtl_pkg::TRIM_KNOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ihtl_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ihtl_pkg::out_t     out_data,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_addr,
  input  wire logic [22:0]   cfg_wdata
);
  import ihtl_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stroke_min   <= 16'd0;
      cfg_r.stroke_max   <= 16'd65535;
      cfg_r.trim_enabled <= 1'b0;
      cfg_r.enter_band   <= 12'd20;
      cfg_r.exit_band    <= 12'd40;
      cfg_r.confirm_ms   <= 16'd100;
      cfg_r.release_ms   <= 16'd100;
      cfg_r.trim_limit   <= 23'd25600;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STROKE_MIN:   cfg_r.stroke_min   <= cfg_wdata[15:0];
        REG_STROKE_MAX:   cfg_r.stroke_max   <= cfg_wdata[15:0];
        REG_TRIM_ENABLED: cfg_r.trim_enabled <= cfg_wdata[0];
        REG_ENTER_BAND:   cfg_r.enter_band   <= cfg_wdata[11:0];
        REG_EXIT_BAND:    cfg_r.exit_band    <= cfg_wdata[11:0];
        REG_CONFIRM_MS:   cfg_r.confirm_ms   <= cfg_wdata[15:0];
        REG_RELEASE_MS:   cfg_r.release_ms   <= cfg_wdata[15:0];
        default:          cfg_r.trim_limit   <= cfg_wdata;
      endcase
    end
  end

  ihtl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  ihtl_datapath #(.TRIM_KNOTS(TRIM_KNOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_data(in_data),
    .cmd(cmd), .sts(sts), .out_data(out_data)
  );

endmodule

`default_nettype wire

>>> tb/integral_hold_trim_learner_chk.sv
// checker for the integral hold trim learner: watches both channels,
// predicts each result beat and compares it field by field
// depends on ihtl_pkg
module integral_hold_trim_learner_chk (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  ihtl_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  ihtl_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_addr,
  input  logic [22:0]    cfg_wdata,
  output int             fail_count,
  output int             pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ihtl_pkg::*;

  localparam int KNOTS = TRIM_KNOTS_DEF;

  // mirrored configuration
  logic [15:0] m_smin, m_smax, m_confirm, m_release;
  logic        m_en;
  logic [11:0] m_enter, m_exit;
  logic [22:0] m_limit;

  // mirrored state
  logic        s_hold, s_epend, s_rpend;
  logic [31:0] s_estart, s_rstart;
  logic signed [23:0] s_knot [KNOTS];
  logic [15:0] s_count;

  out_t step_queue[$];

  initial pending_count = 0;

  // knot coordinate of a position: lower knot, upper knot, weight
  function automatic void find_knots(input logic [15:0] pos, output int lo, output int hi,
                                     output int w);
    longint num, q;
    lo = 0;
    w = 0;
    if (m_smax > m_smin && pos > m_smin) begin
      if (pos >= m_smax) begin
        lo = KNOTS - 1;
      end else begin
        num = longint'(pos - m_smin) * (KNOTS - 1) * 256;
        q = num / longint'(m_smax - m_smin);
        lo = int'(q >> 8);
        w = int'(q & 255);
        if (lo >= KNOTS - 1) begin
          lo = KNOTS - 1;
          w = 0;
        end
      end
    end
    hi = (lo + 1 < KNOTS) ? lo + 1 : lo;
  endfunction

  function automatic logic signed [23:0] trim_lookup(input logic [15:0] pos);
    int lo, hi, w;
    longint sum;
    if (!m_en) return '0;
    find_knots(pos, lo, hi, w);
    sum = longint'(s_knot[lo]) * (256 - w) + longint'(s_knot[hi]) * w + 128;
    return 24'(sum >>> 8);
  endfunction

  function automatic logic deadline_hit(input logic [31:0] now, input logic [31:0] start,
                                        input logic [15:0] dur);
    logic [31:0] d;
    d = now - start;
    return d >= {16'd0, dur};
  endfunction

  // advance the mirrored state by one step
  task automatic predict_step(input in_t it);
    out_t r;
    longint aerr, integ, cl, cu, lim;
    int lo, hi, w;
    logic entered, moved;
    entered = 0;
    moved = 0;
    aerr = longint'(it.control_error);
    if (aerr < 0) aerr = -aerr;
    r.trim_value = trim_lookup(it.query_position);
    if (!it.target_settled) begin
      s_hold = 0; s_epend = 0; s_rpend = 0;
    end else if (!s_hold) begin
      if (aerr > m_enter) begin
        s_epend = 0;
      end else begin
        if (!s_epend) begin
          s_estart = it.now_ms;
          s_epend = 1;
        end
        if (deadline_hit(it.now_ms, s_estart, m_confirm)) begin
          s_hold = 1; entered = 1; s_epend = 0; s_rpend = 0;
        end
      end
    end else if (aerr <= m_exit) begin
      s_rpend = 0;
    end else if (!s_rpend) begin
      s_rpend = 1;
      s_rstart = it.now_ms;
    end else if (deadline_hit(it.now_ms, s_rstart, m_release)) begin
      s_hold = 0; s_epend = 0; s_rpend = 0;
    end
    if (entered && m_en) begin
      find_knots(it.demand_position, lo, hi, w);
      integ = longint'(it.loop_integral);
      lim = longint'(m_limit);
      cl = longint'(s_knot[lo]) + integ;
      cu = longint'(s_knot[hi]) + integ;
      if (!(cl > lim || cl < -lim || cu > lim || cu < -lim ||
            (integ < 128 && integ > -128))) begin
        s_knot[lo] = 24'(cl);
        s_knot[hi] = 24'(cu);
        s_count = s_count + 16'd1;
        moved = 1;
      end
    end
    r.hold_active = s_hold;
    r.hold_entered = entered;
    r.trim_transferred = moved;
    r.transfer_total = s_count;
    step_queue.push_back(r);
  endtask

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      m_smin = 16'd0; m_smax = 16'hffff; m_en = 0;
      m_enter = 12'd20; m_exit = 12'd40; m_confirm = 16'd100; m_release = 16'd100;
      m_limit = 23'd25600;
      s_hold = 0; s_epend = 0; s_rpend = 0; s_estart = 0; s_rstart = 0;
      for (int i = 0; i < KNOTS; i++) s_knot[i] = '0;
      s_count = 0;
      fail_count = 0;
      step_queue.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_STROKE_MIN:   m_smin = cfg_wdata[15:0];
          REG_STROKE_MAX:   m_smax = cfg_wdata[15:0];
          REG_TRIM_ENABLED: m_en = cfg_wdata[0];
          REG_ENTER_BAND:   m_enter = cfg_wdata[11:0];
          REG_EXIT_BAND:    m_exit = cfg_wdata[11:0];
          REG_CONFIRM_MS:   m_confirm = cfg_wdata[15:0];
          REG_RELEASE_MS:   m_release = cfg_wdata[15:0];
          REG_TRIM_LIMIT:   m_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_step(in_data);
      // result beat compare
      if (out_valid && out_ready) begin
        if (step_queue.size() == 0) begin
          $error("result beat with no step waiting");
          fail_count++;
        end else begin
          e = step_queue.pop_front();
          if (out_data.hold_active !== e.hold_active) begin
            $error("hold_active exp %0d got %0d", e.hold_active, out_data.hold_active);
            fail_count++;
          end
          if (out_data.hold_entered !== e.hold_entered) begin
            $error("hold_entered exp %0d got %0d", e.hold_entered, out_data.hold_entered);
            fail_count++;
          end
          if (out_data.trim_transferred !== e.trim_transferred) begin
            $error("trim_transferred exp %0d got %0d", e.trim_transferred,
                   out_data.trim_transferred);
            fail_count++;
          end
          if (out_data.trim_value !== e.trim_value) begin
            $error("trim_value exp %0d got %0d", e.trim_value, out_data.trim_value);
            fail_count++;
          end
          if (out_data.transfer_total !== e.transfer_total) begin
            $error("transfer_total exp %0d got %0d", e.transfer_total,
                   out_data.transfer_total);
            fail_count++;
          end
        end
      end
    end
    pending_count = step_queue.size();
  end
endmodule

>>> tb/integral_hold_trim_learner_tb.sv
// stimulus and verdict for the integral hold trim learner
// depends on ihtl_pkg, integral_hold_trim_learner, integral_hold_trim_learner_chk
module integral_hold_trim_learner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ihtl_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_t        out_data;
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = '0;
  logic [22:0] cfg_wdata = '0;
  int          fail_count;
  int          pending_count;
  logic        quiet = 0;

  // running millisecond clock of the stimulus
  logic [31:0] ms_now = 0;

  always #5 clk = ~clk;

  integral_hold_trim_learner u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_addr, .cfg_wdata
  );

  integral_hold_trim_learner_chk u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_addr, .cfg_wdata,
    .fail_count, .pending_count
  );

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  // valid stays high between beats sent without a gap
  task automatic send_beat(input in_t it);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // write enable stays high across back to back writes
  task automatic cfg_write(input logic [2:0] idx, input logic [22:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_setup(input logic [15:0] smin, input logic [15:0] smax,
                            input logic en, input logic [11:0] eb, input logic [11:0] xb,
                            input logic [15:0] cf, input logic [15:0] rl,
                            input logic [22:0] lim);
    drain();
    cfg_write(REG_STROKE_MIN, 23'(smin));
    cfg_write(REG_STROKE_MAX, 23'(smax));
    cfg_write(REG_TRIM_ENABLED, 23'(en));
    cfg_write(REG_ENTER_BAND, 23'(eb));
    cfg_write(REG_EXIT_BAND, 23'(xb));
    cfg_write(REG_CONFIRM_MS, 23'(cf));
    cfg_write(REG_RELEASE_MS, 23'(rl));
    cfg_write(REG_TRIM_LIMIT, lim);
    cfg_we <= 0;
  endtask

  // one step of a well-formed settle/hold/release sequence, random content
  function automatic in_t shaped_step(input int phase);
    in_t it;
    it.target_settled = ($urandom_range(0, 19) != 0);
    case (phase)
      0: it.control_error = 16'($signed($urandom_range(0, 40)) - 20);
      1: it.control_error = 16'($signed($urandom_range(0, 600)) - 300);
      default: it.control_error = 16'($urandom);
    endcase
    it.now_ms = ms_now;
    it.loop_integral = ($urandom_range(0, 7) == 0) ? 24'($signed($urandom_range(0, 300)) - 150)
                                                   : 24'($urandom);
    if ($urandom_range(0, 3) == 0) it.loop_integral = 24'($signed(it.loop_integral) >>> 10);
    it.demand_position = 16'($urandom);
    it.query_position = 16'($urandom);
    return it;
  endfunction

  initial begin
    in_t it;
    int phase;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: default strokes and bands, trim on with zero timers
    load_setup(16'd0, 16'hffff, 1, 12'd20, 12'd40, 16'd0, 16'd0, 23'd25600);
    it = '0; it.target_settled = 1; it.loop_integral = 24'd1000;
    it.demand_position = 16'd0; it.query_position = 16'hffff;
    send_beat(it);                                  // immediate entry, transfer
    it.control_error = 16'sh7fff; it.query_position = 16'd0; send_beat(it);
    it.control_error = 16'sh8000; it.now_ms = 32'hffffffff; send_beat(it);
    it.control_error = 0; it.loop_integral = 24'sd127; send_beat(it); // too small
    it.target_settled = 0; send_beat(it);           // unsettled clears hold
    it.target_settled = 1; it.loop_integral = 24'sh800000; send_beat(it);
    it.target_settled = 0; send_beat(it);
    it.target_settled = 1; it.loop_integral = 24'sh7fffff; send_beat(it); // over limit
    it.target_settled = 0; send_beat(it);
    it.target_settled = 1; it.loop_integral = -24'sd128; it.demand_position = 16'hffff;
    send_beat(it);
    it.query_position = 16'h8000; send_beat(it);
    // degenerate stroke, wrap-safe deadline
    load_setup(16'd500, 16'd500, 1, 12'hfff, 12'hfff, 16'hffff, 16'hffff, 23'h7fffff);
    it = '0; it.target_settled = 1; it.now_ms = 32'hfffffff0; it.loop_integral = 24'd5000;
    send_beat(it);
    it.now_ms = 32'h0000fff0; send_beat(it);
    it.now_ms = 32'h0000ffef; send_beat(it);
    it.query_position = 16'd400; send_beat(it);
    load_setup(16'hffff, 16'd0, 1, 12'd0, 12'd0, 16'd1, 16'd1, 23'd0);
    it = '0; it.target_settled = 1; send_beat(it); it.now_ms = 1; send_beat(it);
    it.loop_integral = 24'd200; it.now_ms = 2; send_beat(it);

    // random phases under several settings
    for (int s = 0; s < 9; s++) begin
      case (s % 3)
        0: load_setup(16'($urandom_range(0, 3000)), 16'($urandom_range(50000, 65535)), 1,
                      12'($urandom_range(10, 60)), 12'($urandom_range(30, 200)),
                      16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
                      23'($urandom_range(2000, 8388607)));
        1: load_setup(16'($urandom), 16'($urandom), $urandom_range(0, 1),
                      12'($urandom), 12'($urandom), 16'($urandom_range(0, 5)),
                      16'($urandom_range(0, 5)), 23'($urandom));
        default: load_setup(16'd0, 16'hffff, 1, 12'hfff, 12'd0, 16'd3, 16'hffff,
                            23'h7fffff);
      endcase
      if (s == 8) quiet = 1;
      for (int k = 0; k < 100; k++) begin
        phase = (k / 12) % 3;
        ms_now = ms_now + $urandom_range(0, 8);
        if ($urandom_range(0, 40) == 0) ms_now = $urandom;
        it = shaped_step(phase);
        send_beat(it);
      end
    end

    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("** integral_hold_trim_learner: PASSED **");
    end else begin
      $display("** integral_hold_trim_learner: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** integral_hold_trim_learner: FAILED **");
    $finish;
  end
endmodule
